[sv/dtbom_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dtbom_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int DEPTH_BITS_DEF = 24;

    localparam int Q_DEPTH = 4;

    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_TEST = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLEND      = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH      = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT     = 8'd3;

    localparam logic [11:0] RST_WIDTH  = 12'd1920;
    localparam logic [11:0] RST_HEIGHT = 12'd1080;

    localparam logic [31:0] CLEAR_COLOR = 32'h0000_00FF;

    typedef enum logic [1:0] {
        ST_WRITTEN    = 2'd0,
        ST_INVALID    = 2'd1,
        ST_OUTSIDE    = 2'd2,
        ST_DEPTH_FAIL = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] rgba;
    } t_frag_ctl;

    typedef struct packed {
        logic depth_test_on;
        logic blend_on;
    } t_mode;

    // floor(x / 255) for x below 65280 (result fits 8 bits): estimate low by at most one, then correct
    function automatic logic [7:0] f_div255(input logic [15:0] x);
        logic [16:0] sum;
        logic [8:0]  q0;
        logic [16:0] prod;
        logic [16:0] rem;
        logic [8:0]  q;
        sum  = {1'b0, x} + {9'd0, x[15:8]};
        q0   = sum[16:8];
        prod = {q0, 8'd0} - {8'd0, q0};
        rem  = {1'b0, x} - prod;
        q    = (rem >= 17'd255) ? q0 + 9'd1 : q0;
        return q[7:0];
    endfunction

endpackage
`default_nettype wire

[sv/dtbom_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module dtbom_fifo #(
    parameter int DW = 8
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  wire  [DW-1:0] i_data,
    input  wire           i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);
    import dtbom_pkg::*;

    localparam int PB = $clog2(Q_DEPTH);
    localparam int CB = $clog2(Q_DEPTH + 1);

    logic [DW-1:0] r_mem [Q_DEPTH];
    logic [PB-1:0] r_wr_ptr, n_wr_ptr;
    logic [PB-1:0] r_rd_ptr, n_rd_ptr;
    logic [CB-1:0] r_count, n_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CB'(Q_DEPTH));
    assign o_empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PB'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PB'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PB'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PB'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CB'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

[sv/dtbom_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module dtbom_front #(
    parameter int MAX_WIDTH  = dtbom_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtbom_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dtbom_pkg::DEPTH_BITS_DEF,
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_valid,
    input  wire  [87:0]                             i_data,
    input  wire                                     i_frag_ok,
    output logic                                    o_ready,
    input  wire                                     i_q_full,
    input  wire                                     i_clr_busy,
    output logic                                    o_push,
    output dtbom_pkg::t_frag_ctl                    o_q_ctl,
    output logic [AW-1:0]                           o_q_idx,
    output logic [DEPTH_BITS-1:0]                   o_q_depth,
    output dtbom_pkg::t_mode                        o_mode,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire  [dtbom_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire  [dtbom_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import dtbom_pkg::*;

    localparam logic [12:0] MW = 13'(MAX_WIDTH);
    localparam logic [12:0] MH = 13'(MAX_HEIGHT);

    logic        r_depth_test_on;
    logic        r_blend_on;
    logic [11:0] r_view_width;
    logic [11:0] r_view_height;

    logic [12:0] w_w_eff, w_h_eff;
    logic [12:0] w_x, w_y;
    logic        w_outside;

    // hold off register writes while reset is asserted
    assign o_cfg_ready = i_rst_n;
    assign o_mode      = '{depth_test_on: r_depth_test_on, blend_on: r_blend_on};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_test_on <= 1'b1;
            r_blend_on      <= 1'b0;
            r_view_width    <= RST_WIDTH;
            r_view_height   <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEPTH_TEST: r_depth_test_on <= i_cfg_data[0];
                CFG_BLEND:      r_blend_on      <= i_cfg_data[0];
                CFG_WIDTH:      r_view_width    <= i_cfg_data;
                CFG_HEIGHT:     r_view_height   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate the viewport to the store size
    assign w_w_eff = ({1'b0, r_view_width} > MW) ? MW : {1'b0, r_view_width};
    assign w_h_eff = ({1'b0, r_view_height} > MH) ? MH : {1'b0, r_view_height};

    assign w_x = i_data[12:0];
    assign w_y = i_data[25:13];

    assign w_outside = w_x[12] || w_y[12] || (w_x >= w_w_eff) || (w_y >= w_h_eff);

    assign o_ready = !i_q_full && !i_clr_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_q_depth = DEPTH_BITS'(i_data[49:26]);
        o_q_idx   = '0;
        o_q_ctl   = '{status: ST_WRITTEN, rgba: {i_data[57:50], i_data[65:58],
                                               i_data[73:66], i_data[81:74]}};
        if (!i_frag_ok) begin
            o_q_ctl.status = ST_INVALID;
        end else if (w_outside) begin
            o_q_ctl.status = ST_OUTSIDE;
        end else begin
            o_q_idx = AW'(w_y[11:0]) * AW'(w_w_eff) + AW'(w_x[11:0]);
        end
    end

endmodule
`default_nettype wire

[sv/dtbom_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module dtbom_back #(
    parameter int MAX_WIDTH  = dtbom_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtbom_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dtbom_pkg::DEPTH_BITS_DEF,
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT),
    parameter int QW         = 34 + AW + DEPTH_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire dtbom_pkg::t_mode   i_mode,
    input  wire  [QW-1:0]           i_q_data,
    input  wire                     i_q_empty,
    output logic                    o_pop,
    output logic                    o_clr_busy,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [1:0]              o_status,
    output logic [21:0]             o_pixel_at,
    output logic [31:0]             o_color_word
);
    import dtbom_pkg::*;

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);
    localparam logic [DEPTH_BITS-1:0] FAR = '1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_MIX   = 4'b1000
    } t_state;

    logic [DEPTH_BITS-1:0] depth_mem [STORE];
    logic [31:0]           color_mem [STORE];

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    t_frag_ctl             r_ctl;
    logic [AW-1:0]         r_idx;
    logic [DEPTH_BITS-1:0] r_depth;
    logic [DEPTH_BITS-1:0] r_dq;
    logic [31:0]           r_cq;
    logic                  r_depth_ok;
    logic [15:0]           r_sum_r, r_sum_g, r_sum_b;

    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status;
    logic [21:0]           r_out_pixel;
    logic [31:0]           r_out_color;

    t_frag_ctl             w_q_ctl;
    logic [AW-1:0]         w_q_idx;
    logic [DEPTH_BITS-1:0] w_q_depth;

    logic [7:0]  w_inv_a;
    logic        w_out_free;
    logic        w_load;
    t_status     w_status;
    logic [31:0] w_color;
    logic        w_dwe, w_cwe;
    logic [AW-1:0] w_waddr;
    logic [DEPTH_BITS-1:0] w_dwdata;
    logic [31:0]           w_cwdata;

    assign w_q_ctl   = i_q_data[QW-1 -: 34];
    assign w_q_idx   = i_q_data[DEPTH_BITS +: AW];
    assign w_q_depth = i_q_data[DEPTH_BITS-1:0];

    assign o_clr_busy = (r_state == S_CLEAR);
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_load     = (r_state == S_MIX) && w_out_free;
    assign w_inv_a    = 8'd255 - r_ctl.rgba[7:0];

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_MIX;
            S_MIX: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_status = r_ctl.status;
        w_color  = '0;
        if (r_ctl.status == ST_WRITTEN) begin
            if (!r_depth_ok) begin
                w_status = ST_DEPTH_FAIL;
            end else if (i_mode.blend_on) begin
                w_color = {f_div255(r_sum_r), f_div255(r_sum_g), f_div255(r_sum_b), 8'hFF};
            end else begin
                w_color = r_ctl.rgba;
            end
        end
    end

    // clearing pass owns the write port until it ends
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_dwe    = 1'b1;
            w_cwe    = 1'b1;
            w_waddr  = r_clr_addr;
            w_dwdata = FAR;
            w_cwdata = CLEAR_COLOR;
        end else begin
            w_cwe    = w_load && (w_status == ST_WRITTEN);
            w_dwe    = w_cwe && i_mode.depth_test_on;
            w_waddr  = r_idx;
            w_dwdata = r_depth;
            w_cwdata = w_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dwe) begin
            depth_mem[w_waddr] <= w_dwdata;
        end
        if (w_cwe) begin
            color_mem[w_waddr] <= w_cwdata;
        end
        if (o_pop) begin
            r_dq <= depth_mem[w_q_idx];
            r_cq <= color_mem[w_q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl   <= w_q_ctl;
            r_idx   <= w_q_idx;
            r_depth <= w_q_depth;
        end
        if (r_state == S_READ) begin
            r_depth_ok <= !i_mode.depth_test_on || (r_depth < r_dq);
            r_sum_r    <= 16'(r_ctl.rgba[31:24]) * 16'(r_ctl.rgba[7:0])
                        + 16'(r_cq[31:24]) * 16'(w_inv_a);
            r_sum_g    <= 16'(r_ctl.rgba[23:16]) * 16'(r_ctl.rgba[7:0])
                        + 16'(r_cq[23:16]) * 16'(w_inv_a);
            r_sum_b    <= 16'(r_ctl.rgba[15:8]) * 16'(r_ctl.rgba[7:0])
                        + 16'(r_cq[15:8]) * 16'(w_inv_a);
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_pixel  <= 22'(r_idx);
            r_out_color  <= w_color;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_pixel_at   = r_out_pixel;
    assign o_color_word = r_out_color;

endmodule
`default_nettype wire

[sv/depth_test_blend_output_merger_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Raster output merger: depth test (strictly less) and source-alpha blend into on-chip
// depth and RGBA stores of MAX_WIDTH x MAX_HEIGHT entries. After reset a clearing pass
// writes every entry, one per cycle; no fragment is taken until it ends, while
// configuration writes are taken whenever reset is deasserted. The front classifies a
// fragment (invalid, outside the viewport, or its pixel index) in the cycle it is
// accepted and queues it; the back handles one queued fragment at a time in three
// steps: store read, depth compare and blend products, then divide by 255 and write
// back, which waits until the output register is free. The back takes no new fragment
// from the queue until the last one is finished. Every fragment yields exactly one
// result beat, in order; status is 0 written, 1 invalid, 2 outside, 3 depth failed.
module depth_test_blend_output_merger_core #(
    parameter int MAX_WIDTH  = dtbom_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtbom_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dtbom_pkg::DEPTH_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pos_x[12:0], pos_y[25:13], frag_depth[49:26], red_in[57:50],
    // green_in[65:58], blue_in[73:66], alpha_in[81:74], zero[87:82]
    input  wire  [87:0]                         i_s_axis_tdata,
    // frag_ok[0]
    input  wire                                 i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // pixel_at[21:0], color_word[53:22], zero[55:54]
    output logic [55:0]                         o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]                          o_m_axis_tuser,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [dtbom_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [dtbom_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import dtbom_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int QW = 34 + AW + DEPTH_BITS;

    logic                  w_q_full, w_q_empty, w_push, w_pop, w_clr_busy;
    t_frag_ctl             w_push_ctl;
    logic [AW-1:0]         w_push_idx;
    logic [DEPTH_BITS-1:0] w_push_depth;
    logic [QW-1:0]         w_push_data, w_head_data;
    t_mode                 w_mode;
    logic [21:0]           w_pixel_at;
    logic [31:0]           w_color_word;

    dtbom_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS),
        .AW         (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_data      (i_s_axis_tdata),
        .i_frag_ok   (i_s_axis_tuser),
        .o_ready     (o_s_axis_tready),
        .i_q_full    (w_q_full),
        .i_clr_busy  (w_clr_busy),
        .o_push      (w_push),
        .o_q_ctl     (w_push_ctl),
        .o_q_idx     (w_push_idx),
        .o_q_depth   (w_push_depth),
        .o_mode      (w_mode),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign w_push_data = {w_push_ctl, w_push_idx, w_push_depth};

    dtbom_fifo #(
        .DW (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head_data),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    dtbom_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS),
        .AW         (AW),
        .QW         (QW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (w_mode),
        .i_q_data     (w_head_data),
        .i_q_empty    (w_q_empty),
        .o_pop        (w_pop),
        .o_clr_busy   (w_clr_busy),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_status     (o_m_axis_tuser),
        .o_pixel_at   (w_pixel_at),
        .o_color_word (w_color_word)
    );

    assign o_m_axis_tdata = {2'b00, w_color_word, w_pixel_at};

endmodule
`default_nettype wire
